[sv/nfa_epsilon_closure_assert.svh]
// Assertion macros used by the checker of the lambda closure block
`ifndef NFA_EPSILON_CLOSURE_ASSERT_SVH
`define NFA_EPSILON_CLOSURE_ASSERT_SVH

// same-cycle implication
`define NEC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define NEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/nfa_ec_pkg.sv]
// Package: constants, types and op codes of the lambda closure block
`default_nettype none
package nfa_ec_pkg;

  localparam int NumStates = 32;
  localparam int RowW      = $clog2(NumStates);
  localparam int SetW      = 32;
  localparam int OpW       = 2;

  localparam logic [OpW-1:0] OpClear = 2'd0;
  localparam logic [OpW-1:0] OpAdd   = 2'd1;
  localparam logic [OpW-1:0] OpQuery = 2'd2;

  typedef logic [NumStates-1:0] state_vec_t;

  typedef struct packed {
    logic            clr;
    logic            set;
    logic [RowW-1:0] row;
    logic [RowW-1:0] col;
  } edge_cmd_t;

endpackage
`default_nettype wire

[sv/nfa_epsilon_closure.sv]
// Clear and add take effect at the accepting edge. A query walks the closure one
// adjacency row per cycle, a row per state in the closure, then loads the output
// register once it is free. Throughput: one clear/add per cycle while no query is
// walking; the input stalls from an accepted query until its closure is loaded.
// The output register lets the next item enter while a closure waits to be taken.
// Reset (async, active low) clears the edge matrix, reached/frontier sets and valid.
`default_nettype none
module nfa_epsilon_closure
  import nfa_ec_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [OpW-1:0]  operation_i,
  input  wire logic [4:0]      source_state_i,
  input  wire logic [7:0]      symbol_i,
  input  wire logic [4:0]      target_state_i,
  input  wire logic [SetW-1:0] start_set_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [SetW-1:0]      closure_set_o
);

  edge_cmd_t  cmd;
  state_vec_t row_sel;
  state_vec_t row;

  nfa_ec_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .source_state_i (source_state_i),
    .symbol_i       (symbol_i),
    .target_state_i (target_state_i),
    .start_set_i    (start_set_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .closure_set_o  (closure_set_o),
    .cmd_o          (cmd),
    .row_sel_o      (row_sel),
    .row_i          (row)
  );

  nfa_ec_edges u_edges (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .row_sel_i (row_sel),
    .row_o     (row)
  );

endmodule
`default_nettype wire

[sv/nfa_ec_edges.sv]
// Lambda edge adjacency matrix with one-hot row read
`default_nettype none
module nfa_ec_edges
  import nfa_ec_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire edge_cmd_t  cmd_i,
  input  wire state_vec_t row_sel_i,
  output state_vec_t      row_o
);

  state_vec_t edges_q [NumStates];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStates; i++) edges_q[i] <= '0;
    end else if (cmd_i.clr) begin
      for (int i = 0; i < NumStates; i++) edges_q[i] <= '0;
    end else if (cmd_i.set) begin
      edges_q[cmd_i.row][cmd_i.col] <= 1'b1;
    end
  end

  always_comb begin
    row_o = '0;
    for (int i = 0; i < NumStates; i++) begin
      if (row_sel_i[i]) row_o = row_o | edges_q[i];
    end
  end

endmodule
`default_nettype wire

[sv/nfa_ec_ctrl.sv]
// Sequencer: frontier walk, reached set and output register
`default_nettype none
module nfa_ec_ctrl
  import nfa_ec_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [OpW-1:0]   operation_i,
  input  wire logic [4:0]       source_state_i,
  input  wire logic [7:0]       symbol_i,
  input  wire logic [4:0]       target_state_i,
  input  wire logic [SetW-1:0]  start_set_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [SetW-1:0]       closure_set_o,
  output edge_cmd_t             cmd_o,
  output state_vec_t            row_sel_o,
  input  wire state_vec_t       row_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic       state_q, state_d;
  state_vec_t reached_q, reached_d;
  state_vec_t frontier_q, frontier_d;
  logic       out_valid_q, out_valid_d;
  logic [SetW-1:0] closure_q, closure_d;

  logic       accept;
  state_vec_t low_bit;
  state_vec_t fresh;
  logic       deliver;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q == StWalk);
  assign low_bit   = frontier_q & (~frontier_q + state_vec_t'(1));
  assign row_sel_o = (state_q == StWalk) ? low_bit : '0;
  assign fresh     = row_i & ~reached_q;
  assign deliver   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o     = '0;
    cmd_o.row = source_state_i[RowW-1:0];
    cmd_o.col = target_state_i[RowW-1:0];
    if (accept && state_q == StIdle) begin
      case (operation_i)
        OpClear: cmd_o.clr = 1'b1;
        OpAdd:   cmd_o.set = (symbol_i == 8'd0) && (int'(source_state_i) < NumStates)
                             && (int'(target_state_i) < NumStates);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    reached_d   = reached_q;
    frontier_d  = frontier_q;
    out_valid_d = out_valid_q && out_stall_i;
    closure_d   = closure_q;
    case (state_q)
      StIdle: begin
        if (accept && operation_i == OpQuery) begin
          reached_d  = state_vec_t'(start_set_i);
          frontier_d = state_vec_t'(start_set_i);
          state_d    = StWalk;
        end
      end
      StWalk: begin
        if (frontier_q != '0) begin
          reached_d  = reached_q | fresh;
          frontier_d = (frontier_q & ~low_bit) | fresh;
        end else if (deliver) begin
          out_valid_d = 1'b1;
          closure_d   = SetW'(reached_q);
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      reached_q   <= '0;
      frontier_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      reached_q   <= reached_d;
      frontier_q  <= frontier_d;
    end
  end

  always_ff @(posedge clk_i) begin
    closure_q <= closure_d;
  end

  assign out_valid_o   = out_valid_q;
  assign closure_set_o = closure_q;

endmodule
`default_nettype wire

[sv/nfa_ec_checker.sv]
// Port-level checker for the lambda closure block, bound to the top level
`default_nettype none
`include "nfa_epsilon_closure_assert.svh"
module nfa_ec_checker
  import nfa_ec_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire logic [OpW-1:0]  operation_i,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire logic [SetW-1:0] closure_set_o
);

  `NEC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(closure_set_o))
  `NEC_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && operation_i == OpQuery,
                   in_stall_o)
  `NEC_ASSERT_NEXT(a_table_op_free, in_valid_i && !in_stall_o && operation_i != OpQuery,
                   !in_stall_o)
  `NEC_ASSERT(a_result_from_walk, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind nfa_epsilon_closure nfa_ec_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .closure_set_o (closure_set_o)
);
`default_nettype wire
